// ===== rtl/core/mblr_pkg.sv =====
// ----------------------------------------------------------------------------
// mblr_pkg
// Shared types, codes and constants of the MIDI binding learn router.
// ----------------------------------------------------------------------------
package mblr_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam int REQ_W     = 2;
    localparam int CHAN_W    = 4;
    localparam int CTRL_W    = 7;
    localparam int TSLOT_W   = 4;
    localparam int VAL14_W   = 14;
    localparam int CC_KEY_W  = CHAN_W + CTRL_W;
    localparam int LP_W      = 5;
    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_EVENT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ARM   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CC      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NRPN    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LEARNED = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_HIGH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEL_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LOW  = 2'd3;

    localparam logic [CTRL_W-1:0] SEL_HIGH_RST   = 7'd99;
    localparam logic [CTRL_W-1:0] SEL_LOW_RST    = 7'd98;
    localparam logic [CTRL_W-1:0] ENTRY_HIGH_RST = 7'd6;
    localparam logic [CTRL_W-1:0] ENTRY_LOW_RST  = 7'd38;

    // one entry of the slot RAM
    typedef struct packed {
        logic [LP_W-1:0]     lp;
        logic [CC_KEY_W-1:0] cc_key;
        logic [VAL14_W-1:0]  nrpn_key;
    } slot_word_t;

    // per-field write enables of the slot RAM
    typedef struct packed {
        logic lp;
        logic cc_key;
        logic nrpn_key;
    } slot_wmask_t;

    // decode of a controller event against the NRPN state
    typedef struct packed {
        logic               is_nrpn;
        logic               complete;
        logic [VAL14_W-1:0] key;
        logic [VAL14_W-1:0] dval;
    } nrpn_dec_t;

    typedef struct packed {
        logic [TSLOT_W-1:0] slot_index;
        logic [VAL14_W-1:0] slot_value;
        logic               value_is_14bit;
        logic [KIND_W-1:0]  event_kind;
        logic               handled;
        logic               last_result;
    } result_t;

endpackage

// ===== rtl/core/mblr_slot_ram.sv =====
// ----------------------------------------------------------------------------
// mblr_slot_ram
// Per-slot RAM: learn position, CC key and NRPN key, with field write enables.
// ----------------------------------------------------------------------------
module mblr_slot_ram #(
    parameter int NUM_SLOTS = mblr_pkg::NUM_SLOTS_DEF,
    parameter int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  mblr_pkg::slot_wmask_t wr_mask,
    input  logic [SLOT_W-1:0]    wr_addr,
    input  mblr_pkg::slot_word_t wr_data,
    input  logic                 rd_en,
    input  logic [SLOT_W-1:0]    rd_addr,
    output mblr_pkg::slot_word_t rd_data
);

    mblr_pkg::slot_word_t mem [NUM_SLOTS];
    mblr_pkg::slot_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (wr_mask.lp) begin
                mem[wr_addr].lp <= wr_data.lp;
            end
            if (wr_mask.cc_key) begin
                mem[wr_addr].cc_key <= wr_data.cc_key;
            end
            if (wr_mask.nrpn_key) begin
                mem[wr_addr].nrpn_key <= wr_data.nrpn_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/mblr_nrpn.sv =====
// ----------------------------------------------------------------------------
// mblr_nrpn
// NRPN controller registers and parameter/data byte tracking.
// ----------------------------------------------------------------------------
module mblr_nrpn (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [mblr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mblr_pkg::CTRL_W-1:0]        cfg_data,
    input  logic                               ev_accept,
    input  logic [mblr_pkg::CHAN_W-1:0]        midi_channel,
    input  logic [mblr_pkg::CTRL_W-1:0]        controller_number,
    input  logic [mblr_pkg::CTRL_W-1:0]        controller_value,
    output mblr_pkg::nrpn_dec_t                dec
);

    logic [mblr_pkg::CTRL_W-1:0] sel_hi_reg, sel_lo_reg, ent_hi_reg, ent_lo_reg;

    logic                        ph_v_reg, pl_v_reg, dh_v_reg, dl_v_reg;
    logic                        ph_v_next, pl_v_next, dh_v_next, dl_v_next;
    logic [mblr_pkg::CTRL_W-1:0] ph_reg, pl_reg, dh_reg, dl_reg;
    logic [mblr_pkg::CTRL_W-1:0] ph_next, pl_next, dh_next, dl_next;
    logic                        is_nrpn;
    logic                        params_ok;

    always_comb begin
        ph_v_next = ph_v_reg;
        pl_v_next = pl_v_reg;
        dh_v_next = dh_v_reg;
        dl_v_next = dl_v_reg;
        ph_next   = ph_reg;
        pl_next   = pl_reg;
        dh_next   = dh_reg;
        dl_next   = dl_reg;
        is_nrpn   = 1'b1;
        params_ok = ph_v_reg && pl_v_reg;
        // equal register values: select high wins, then select low, entry high, entry low
        if (controller_number == sel_hi_reg) begin
            ph_v_next = 1'b1;
            ph_next   = controller_value;
            dh_v_next = 1'b0;
            dl_v_next = 1'b0;
        end else if (controller_number == sel_lo_reg) begin
            pl_v_next = 1'b1;
            pl_next   = controller_value;
            dh_v_next = 1'b0;
            dl_v_next = 1'b0;
        end else if (controller_number == ent_hi_reg) begin
            if (params_ok) begin
                dh_v_next = 1'b1;
                dh_next   = controller_value;
            end
        end else if (controller_number == ent_lo_reg) begin
            if (params_ok) begin
                dl_v_next = 1'b1;
                dl_next   = controller_value;
            end
        end else begin
            is_nrpn = 1'b0;
        end
    end

    always_comb begin
        dec.is_nrpn  = is_nrpn;
        dec.complete = is_nrpn ? (ph_v_next && pl_v_next && dh_v_next && dl_v_next) : 1'b1;
        dec.key      = is_nrpn ? {ph_next, pl_next}
                               : mblr_pkg::VAL14_W'({midi_channel, controller_number});
        dec.dval     = {dh_next, dl_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_hi_reg <= mblr_pkg::SEL_HIGH_RST;
            sel_lo_reg <= mblr_pkg::SEL_LOW_RST;
            ent_hi_reg <= mblr_pkg::ENTRY_HIGH_RST;
            ent_lo_reg <= mblr_pkg::ENTRY_LOW_RST;
            ph_v_reg   <= 1'b0;
            pl_v_reg   <= 1'b0;
            dh_v_reg   <= 1'b0;
            dl_v_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mblr_pkg::CFG_SEL_HIGH:   sel_hi_reg <= cfg_data;
                    mblr_pkg::CFG_SEL_LOW:    sel_lo_reg <= cfg_data;
                    mblr_pkg::CFG_ENTRY_HIGH: ent_hi_reg <= cfg_data;
                    mblr_pkg::CFG_ENTRY_LOW:  ent_lo_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ev_accept) begin
                ph_v_reg <= ph_v_next;
                pl_v_reg <= pl_v_next;
                dh_v_reg <= dh_v_next;
                dl_v_reg <= dl_v_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_accept) begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
            dh_reg <= dh_next;
            dl_reg <= dl_next;
        end
    end

endmodule

// ===== rtl/core/mblr_seq.sv =====
// ----------------------------------------------------------------------------
// mblr_seq
// Item sequencer: slot table scan, learn queue upkeep and result staging.
// ----------------------------------------------------------------------------
module mblr_seq #(
    parameter int NUM_SLOTS = mblr_pkg::NUM_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mblr_pkg::REQ_W-1:0]    req_type,
    input  logic [mblr_pkg::CTRL_W-1:0]   controller_value,
    input  logic [mblr_pkg::TSLOT_W-1:0]  target_slot,
    input  mblr_pkg::nrpn_dec_t           dec,
    output logic                          ev_accept,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mblr_pkg::result_t             m_result
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_SLOTS);
    localparam logic [mblr_pkg::RES_CNT_W-1:0] RES_CAP =
        mblr_pkg::RES_CNT_W'(mblr_pkg::MAX_RESULTS);
    localparam logic [mblr_pkg::LP_W-1:0] LP_HEAD = mblr_pkg::LP_W'(1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CLR_RD = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DROP   = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t                              state_reg, state_next;
    logic [mblr_pkg::LP_W-1:0]           len_reg, len_next, len_dec;
    logic [NUM_SLOTS-1:0]                cc_v_reg, cc_v_next;
    logic [NUM_SLOTS-1:0]                nrpn_v_reg, nrpn_v_next;
    logic [NUM_SLOTS-1:0]                lp_v_reg, lp_v_next;
    logic [CNT_W-1:0]                    rd_cnt_reg, rd_cnt_next;
    logic                                cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic [mblr_pkg::RES_CNT_W-1:0]      res_cnt_reg, res_cnt_next;
    logic                                bound_reg, bound_next;
    logic                                found_reg, found_next;
    logic [SLOT_W-1:0]                   learn_idx_reg, learn_idx_next;
    logic [mblr_pkg::LP_W-1:0]           drop_pos_reg, drop_pos_next;
    logic                                is_nrpn_reg, is_nrpn_next;
    logic [mblr_pkg::VAL14_W-1:0]        key_reg, key_next;
    logic [mblr_pkg::VAL14_W-1:0]        dval_reg, dval_next;
    logic [mblr_pkg::CTRL_W-1:0]         cval_reg, cval_next;
    mblr_pkg::result_t                   pend_reg, pend_next;
    logic                                pend_valid_reg, pend_valid_next;
    mblr_pkg::result_t                   out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    logic                  ram_wr_en;
    mblr_pkg::slot_wmask_t ram_wr_mask;
    logic [SLOT_W-1:0]     ram_wr_addr;
    mblr_pkg::slot_word_t  ram_wr_data;
    logic                  ram_rd_en;
    logic [SLOT_W-1:0]     ram_rd_addr;
    mblr_pkg::slot_word_t  word;

    logic                  accept;
    logic                  in_range;
    logic [SLOT_W-1:0]     tgt_idx;
    logic                  out_free;
    logic                  rd_more;
    logic                  match;
    logic                  emit_new;
    logic                  stall;
    logic                  push;
    mblr_pkg::result_t     push_data;

    function automatic mblr_pkg::result_t mk_result(
        input logic [mblr_pkg::TSLOT_W-1:0] slot,
        input logic [mblr_pkg::VAL14_W-1:0] value,
        input logic                         is14,
        input logic [mblr_pkg::KIND_W-1:0]  kind,
        input logic                         handled
    );
        mblr_pkg::result_t r;
        r.slot_index     = slot;
        r.slot_value     = value;
        r.value_is_14bit = is14;
        r.event_kind     = kind;
        r.handled        = handled;
        r.last_result    = 1'b0;
        return r;
    endfunction

    mblr_slot_ram #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_mask (ram_wr_mask),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (word)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign ev_accept = accept && (req_type == mblr_pkg::REQ_EVENT);
    assign in_range  = (32'(target_slot) < NUM_SLOTS);
    assign tgt_idx   = SLOT_W'(target_slot);
    assign out_free  = !out_valid_reg || m_ready;
    assign rd_more   = (rd_cnt_reg != SCAN_END);
    assign len_dec   = (len_reg != '0) ? len_reg - mblr_pkg::LP_W'(1) : len_reg;

    always_comb begin
        match = 1'b0;
        if (cmp_valid_reg) begin
            if (is_nrpn_reg) begin
                match = nrpn_v_reg[cmp_idx_reg] && (word.nrpn_key == key_reg);
            end else begin
                match = cc_v_reg[cmp_idx_reg] &&
                        (word.cc_key == key_reg[mblr_pkg::CC_KEY_W-1:0]);
            end
        end
        emit_new = (state_reg == ST_SCAN) && match && (res_cnt_reg != RES_CAP);
        stall    = emit_new && pend_valid_reg && !out_free;
    end

    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        cc_v_next       = cc_v_reg;
        nrpn_v_next     = nrpn_v_reg;
        lp_v_next       = lp_v_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        res_cnt_next    = res_cnt_reg;
        bound_next      = bound_reg;
        found_next      = found_reg;
        learn_idx_next  = learn_idx_reg;
        drop_pos_next   = drop_pos_reg;
        is_nrpn_next    = is_nrpn_reg;
        key_next        = key_reg;
        dval_next       = dval_reg;
        cval_next       = cval_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        push            = 1'b0;
        push_data       = pend_reg;

        ram_wr_en   = 1'b0;
        ram_wr_mask = '0;
        ram_wr_addr = cmp_idx_reg;
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = rd_cnt_reg[SLOT_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_valid_next = 1'b1;
                    state_next      = ST_EMIT;
                    case (req_type)
                        mblr_pkg::REQ_ARM: begin
                            pend_next = mk_result(target_slot, '0, 1'b0,
                                                  mblr_pkg::KIND_ACK, 1'b0);
                            if (in_range && !lp_v_reg[tgt_idx] && !cc_v_reg[tgt_idx]) begin
                                len_next          = len_reg + mblr_pkg::LP_W'(1);
                                pend_next.handled = 1'b1;
                                // a wrapped queue length leaves the slot not learning
                                if (len_next != '0) begin
                                    lp_v_next[tgt_idx] = 1'b1;
                                    ram_wr_en          = 1'b1;
                                    ram_wr_mask.lp     = 1'b1;
                                    ram_wr_addr        = tgt_idx;
                                    ram_wr_data.lp     = len_next;
                                end
                            end
                        end
                        mblr_pkg::REQ_CLEAR: begin
                            pend_next = mk_result(target_slot, '0, 1'b0,
                                                  mblr_pkg::KIND_ACK, in_range);
                            if (in_range) begin
                                cc_v_next[tgt_idx]   = 1'b0;
                                nrpn_v_next[tgt_idx] = 1'b0;
                                if (lp_v_reg[tgt_idx]) begin
                                    lp_v_next[tgt_idx] = 1'b0;
                                    ram_rd_en          = 1'b1;
                                    ram_rd_addr        = tgt_idx;
                                    state_next         = ST_CLR_RD;
                                end
                            end
                        end
                        mblr_pkg::REQ_EVENT: begin
                            is_nrpn_next = dec.is_nrpn;
                            key_next     = dec.key;
                            dval_next    = dec.dval;
                            cval_next    = controller_value;
                            pend_next    = mk_result('0, '0, 1'b0, mblr_pkg::KIND_NONE, 1'b0);
                            if (dec.complete) begin
                                pend_valid_next = 1'b0;
                                rd_cnt_next     = '0;
                                cmp_valid_next  = 1'b0;
                                res_cnt_next    = '0;
                                bound_next      = 1'b0;
                                found_next      = 1'b0;
                                state_next      = ST_SCAN;
                            end
                        end
                        default: begin
                            pend_next = mk_result('0, '0, 1'b0, mblr_pkg::KIND_NONE, 1'b0);
                        end
                    endcase
                end
            end

            ST_CLR_RD: begin
                drop_pos_next  = word.lp;
                len_next       = len_dec;
                rd_cnt_next    = '0;
                cmp_valid_next = 1'b0;
                state_next     = ST_DROP;
            end

            ST_DROP: begin
                // close the gap in the queue: positions behind the dropped one move up
                if (rd_more) begin
                    ram_rd_en      = 1'b1;
                    rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_cnt_reg[SLOT_W-1:0];
                end else begin
                    cmp_valid_next = 1'b0;
                end
                if (cmp_valid_reg && lp_v_reg[cmp_idx_reg] && (word.lp > drop_pos_reg)) begin
                    ram_wr_en      = 1'b1;
                    ram_wr_mask.lp = 1'b1;
                    ram_wr_addr    = cmp_idx_reg;
                    ram_wr_data.lp = word.lp - mblr_pkg::LP_W'(1);
                end
                if (!rd_more && !cmp_valid_reg) begin
                    state_next = ST_EMIT;
                end
            end

            ST_SCAN: begin
                if (!stall) begin
                    if (rd_more) begin
                        ram_rd_en      = 1'b1;
                        rd_cnt_next    = rd_cnt_reg + CNT_W'(1);
                        cmp_valid_next = 1'b1;
                        cmp_idx_next   = rd_cnt_reg[SLOT_W-1:0];
                    end else begin
                        cmp_valid_next = 1'b0;
                    end
                    if (cmp_valid_reg && !found_reg && lp_v_reg[cmp_idx_reg] &&
                        (word.lp == LP_HEAD)) begin
                        found_next     = 1'b1;
                        learn_idx_next = cmp_idx_reg;
                    end
                    // hold one result back so the final one can carry last
                    if (emit_new) begin
                        if (pend_valid_reg) begin
                            push = 1'b1;
                        end
                        if (is_nrpn_reg) begin
                            pend_next = mk_result(mblr_pkg::TSLOT_W'(cmp_idx_reg), dval_reg,
                                                  1'b1, mblr_pkg::KIND_NRPN, 1'b1);
                        end else begin
                            pend_next = mk_result(mblr_pkg::TSLOT_W'(cmp_idx_reg),
                                                  mblr_pkg::VAL14_W'(cval_reg),
                                                  1'b0, mblr_pkg::KIND_CC, 1'b1);
                        end
                        pend_valid_next = 1'b1;
                        res_cnt_next    = res_cnt_reg + mblr_pkg::RES_CNT_W'(1);
                        bound_next      = 1'b1;
                    end
                    if (!rd_more && !cmp_valid_reg) begin
                        if (bound_reg) begin
                            state_next = ST_EMIT;
                        end else if (found_reg) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = learn_idx_reg;
                            if (is_nrpn_reg) begin
                                ram_wr_mask.nrpn_key       = 1'b1;
                                ram_wr_data.nrpn_key       = key_reg;
                                nrpn_v_next[learn_idx_reg] = 1'b1;
                            end else begin
                                ram_wr_mask.cc_key       = 1'b1;
                                ram_wr_data.cc_key       = key_reg[mblr_pkg::CC_KEY_W-1:0];
                                cc_v_next[learn_idx_reg] = 1'b1;
                            end
                            lp_v_next[learn_idx_reg] = 1'b0;
                            len_next        = len_dec;
                            drop_pos_next   = LP_HEAD;
                            rd_cnt_next     = '0;
                            cmp_valid_next  = 1'b0;
                            pend_next       = mk_result(mblr_pkg::TSLOT_W'(learn_idx_reg),
                                                        mblr_pkg::VAL14_W'(cval_reg), 1'b0,
                                                        mblr_pkg::KIND_LEARNED, 1'b0);
                            pend_valid_next = 1'b1;
                            state_next      = ST_DROP;
                        end else begin
                            pend_next       = mk_result('0, '0, 1'b0,
                                                        mblr_pkg::KIND_NONE, 1'b0);
                            pend_valid_next = 1'b1;
                            state_next      = ST_EMIT;
                        end
                    end
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    push                  = 1'b1;
                    push_data.last_result = 1'b1;
                    pend_valid_next       = 1'b0;
                    state_next            = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (push) begin
            out_next       = push_data;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            cc_v_reg       <= '0;
            nrpn_v_reg     <= '0;
            lp_v_reg       <= '0;
            rd_cnt_reg     <= '0;
            cmp_valid_reg  <= 1'b0;
            res_cnt_reg    <= '0;
            bound_reg      <= 1'b0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            cc_v_reg       <= cc_v_next;
            nrpn_v_reg     <= nrpn_v_next;
            lp_v_reg       <= lp_v_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_valid_reg  <= cmp_valid_next;
            res_cnt_reg    <= res_cnt_next;
            bound_reg      <= bound_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg   <= cmp_idx_next;
        learn_idx_reg <= learn_idx_next;
        drop_pos_reg  <= drop_pos_next;
        is_nrpn_reg   <= is_nrpn_next;
        key_reg       <= key_next;
        dval_reg      <= dval_next;
        cval_reg      <= cval_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

// ===== rtl/core/midi_binding_learn_router.sv =====
// ----------------------------------------------------------------------------
// midi_binding_learn_router
// Routes MIDI controller and NRPN events to learnt automation slots.
// ----------------------------------------------------------------------------
// One item in flight at a time. Arm requests, clears of a non-learning slot,
// incomplete NRPN events and the unused request code do not walk the slot
// RAM. A controller event walks the slot RAM one slot per cycle unless the
// result output holds it back; a learn adds a second walk to renumber the
// learn queue, and a clear of a learning slot walks it for the same reason.
// The pace is set by the single read port of the slot RAM. Every item gives
// at least one result; the last one of an item has tlast set.
// ----------------------------------------------------------------------------
module midi_binding_learn_router #(
    parameter int NUM_SLOTS = mblr_pkg::NUM_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mblr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mblr_pkg::CTRL_W-1:0]        cfg_data,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,  // midi_channel, controller_number,
                                                         // controller_value, target_slot
    input  logic [1:0]                         s_tuser,  // req_type
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [23:0]                        m_tdata,  // slot_index, slot_value, handled
    output logic [3:0]                         m_tuser,  // value_is_14bit, event_kind
    output logic                               m_tlast
);

    mblr_pkg::nrpn_dec_t dec;
    mblr_pkg::result_t   res;
    logic                ev_accept;
    logic                cfg_we;

    logic [mblr_pkg::CHAN_W-1:0]  midi_channel;
    logic [mblr_pkg::CTRL_W-1:0]  controller_number;
    logic [mblr_pkg::CTRL_W-1:0]  controller_value;
    logic [mblr_pkg::TSLOT_W-1:0] target_slot;

    assign midi_channel      = s_tdata[3:0];
    assign controller_number = s_tdata[10:4];
    assign controller_value  = s_tdata[17:11];
    assign target_slot       = s_tdata[21:18];

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    mblr_nrpn u_nrpn (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .ev_accept         (ev_accept),
        .midi_channel      (midi_channel),
        .controller_number (controller_number),
        .controller_value  (controller_value),
        .dec               (dec)
    );

    mblr_seq #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_tvalid),
        .s_ready          (s_tready),
        .req_type         (s_tuser),
        .controller_value (controller_value),
        .target_slot      (target_slot),
        .dec              (dec),
        .ev_accept        (ev_accept),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_result         (res)
    );

    assign m_tdata = {5'b0, res.handled, res.slot_value, res.slot_index};
    assign m_tuser = {res.event_kind, res.value_is_14bit};
    assign m_tlast = res.last_result;

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in progress");

    a_none_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:1] == mblr_pkg::KIND_NONE) |-> m_tlast && !m_tdata[18])
        else $error("empty result not final or flagged handled");

    a_learned_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:1] == mblr_pkg::KIND_LEARNED) |-> m_tlast && !m_tdata[18])
        else $error("learned result not final or flagged handled");

    a_ack_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[3:1] == mblr_pkg::KIND_ACK) |-> m_tlast && !m_tuser[0])
        else $error("request ack not final or marked 14-bit");

endmodule
